// File: design/hpt_pkg.sv
// Shared types and constants of the homography point transform.
package hpt_pkg;

  localparam int CW  = 32;   // coefficient width
  localparam int XW  = 16;   // source coordinate width
  localparam int OW  = 20;   // result coordinate width
  localparam int PW  = 49;   // coefficient times coordinate
  localparam int SW  = 51;   // signed numerator and denominator sums
  localparam int DW  = 50;   // magnitudes, divisor and remainder
  localparam int QW  = 22;   // quotient bits (twice the result, for rounding)
  localparam int SHW = 7;    // numerator pre-shift that lines up with the quotient window
  localparam int NUM_REGS = 8;
  localparam int IW  = 8;    // configuration index width
  localparam int AW  = 3;    // register file address width

  localparam logic [AW-1:0] REG_COEF_XX  = 3'd0;
  localparam logic [AW-1:0] REG_COEF_XY  = 3'd1;
  localparam logic [AW-1:0] REG_OFFSET_X = 3'd2;
  localparam logic [AW-1:0] REG_COEF_YX  = 3'd3;
  localparam logic [AW-1:0] REG_COEF_YY  = 3'd4;
  localparam logic [AW-1:0] REG_OFFSET_Y = 3'd5;
  localparam logic [AW-1:0] REG_PERSP_X  = 3'd6;
  localparam logic [AW-1:0] REG_PERSP_Y  = 3'd7;

  localparam logic signed [CW-1:0] UNITY = 32'sd65536;

  localparam logic signed [OW-1:0] OUT_MAX = 20'sh7FFFF;
  localparam logic signed [OW-1:0] OUT_MIN = 20'sh80000;

  typedef logic signed [CW-1:0] coef_t;

  // Work carried from one division cell to the next.
  typedef struct packed {
    logic [DW-1:0] rx;
    logic [DW-1:0] ry;
    logic [DW-1:0] d;
    logic [QW-1:0] qx;
    logic [QW-1:0] qy;
    logic          negx;
    logic          negy;
    logic          ovx;
    logic          ovy;
    logic          inv;
  } cell_t;

endpackage

// File: design/hpt_point_if.sv
// Source point channel.
interface hpt_point_if;
  logic                       valid;
  logic                       ready;
  logic [hpt_pkg::XW-1:0]     src_x;
  logic [hpt_pkg::XW-1:0]     src_y;
  modport source (output valid, src_x, src_y, input ready);
  modport sink (input valid, src_x, src_y, output ready);
endinterface

// File: design/hpt_result_if.sv
// Mapped point channel.
interface hpt_result_if;
  logic                          valid;
  logic                          ready;
  logic signed [hpt_pkg::OW-1:0] dst_x;
  logic signed [hpt_pkg::OW-1:0] dst_y;
  logic                          invalid;
  logic                          saturated;
  modport source (output valid, dst_x, dst_y, invalid, saturated, input ready);
  modport sink (input valid, dst_x, dst_y, invalid, saturated, output ready);
endinterface

// File: design/hpt_cfg_if.sv
// Configuration write channel.
interface hpt_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [hpt_pkg::IW-1:0]    index;
  logic [hpt_pkg::CW-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/hpt_front.sv
// Multiply, sum and divider setup stages.
module hpt_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [hpt_pkg::XW-1:0]      x,
  input  logic [hpt_pkg::XW-1:0]      y,
  input  hpt_pkg::coef_t              coef [hpt_pkg::NUM_REGS],
  output logic                        out_valid,
  input  logic                        out_ready,
  output hpt_pkg::cell_t              out_cell
);

  logic v1, v2, v3;
  logic en1, en2, en3;

  logic signed [hpt_pkg::PW-1:0] p [6];
  logic signed [hpt_pkg::PW-1:0] ox, oy;
  logic signed [hpt_pkg::SW-1:0] u, v, w;

  logic signed [hpt_pkg::XW:0]   sx, sy;
  logic [hpt_pkg::SW-1:0]        an_x, an_y, an_w;
  logic                          ovx_c, ovy_c, inv_c;

  assign en3 = !v3 || out_ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  assign sx = $signed({1'b0, x});
  assign sy = $signed({1'b0, y});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // Stage 1: six products and the scaled offsets.
  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      p[0] <= coef[hpt_pkg::REG_COEF_XX] * sx;
      p[1] <= coef[hpt_pkg::REG_COEF_XY] * sy;
      p[2] <= coef[hpt_pkg::REG_COEF_YX] * sx;
      p[3] <= coef[hpt_pkg::REG_COEF_YY] * sy;
      p[4] <= coef[hpt_pkg::REG_PERSP_X] * sx;
      p[5] <= coef[hpt_pkg::REG_PERSP_Y] * sy;
      ox   <= $signed({{(hpt_pkg::PW-hpt_pkg::CW-8){coef[hpt_pkg::REG_OFFSET_X][31]}},
                       coef[hpt_pkg::REG_OFFSET_X], 8'd0});
      oy   <= $signed({{(hpt_pkg::PW-hpt_pkg::CW-8){coef[hpt_pkg::REG_OFFSET_Y][31]}},
                       coef[hpt_pkg::REG_OFFSET_Y], 8'd0});
    end
  end

  // Stage 2: numerators and denominator; w carries a one at bit 44.
  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      u <= hpt_pkg::SW'(p[0]) + hpt_pkg::SW'(p[1]) + hpt_pkg::SW'(ox);
      v <= hpt_pkg::SW'(p[2]) + hpt_pkg::SW'(p[3]) + hpt_pkg::SW'(oy);
      w <= hpt_pkg::SW'(p[4]) + hpt_pkg::SW'(p[5]) + (hpt_pkg::SW'(1) <<< 44);
    end
  end

  // Stage 3: magnitudes, signs and quotient overflow.
  always_comb begin
    an_x  = u[hpt_pkg::SW-1] ? hpt_pkg::SW'(-u) : hpt_pkg::SW'(u);
    an_y  = v[hpt_pkg::SW-1] ? hpt_pkg::SW'(-v) : hpt_pkg::SW'(v);
    an_w  = w[hpt_pkg::SW-1] ? hpt_pkg::SW'(-w) : hpt_pkg::SW'(w);
    inv_c = (w == '0);
    ovx_c = {an_x[hpt_pkg::DW-1:0], hpt_pkg::SHW'(0)} >=
            {hpt_pkg::SHW'(0), an_w[hpt_pkg::DW-1:0]};
    ovy_c = {an_y[hpt_pkg::DW-1:0], hpt_pkg::SHW'(0)} >=
            {hpt_pkg::SHW'(0), an_w[hpt_pkg::DW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      out_cell.rx   <= (ovx_c || inv_c) ? '0 :
                       {an_x[hpt_pkg::DW-hpt_pkg::SHW-1:0], hpt_pkg::SHW'(0)};
      out_cell.ry   <= (ovy_c || inv_c) ? '0 :
                       {an_y[hpt_pkg::DW-hpt_pkg::SHW-1:0], hpt_pkg::SHW'(0)};
      out_cell.d    <= an_w[hpt_pkg::DW-1:0];
      out_cell.qx   <= '0;
      out_cell.qy   <= '0;
      out_cell.negx <= u[hpt_pkg::SW-1] ^ w[hpt_pkg::SW-1];
      out_cell.negy <= v[hpt_pkg::SW-1] ^ w[hpt_pkg::SW-1];
      out_cell.ovx  <= ovx_c;
      out_cell.ovy  <= ovy_c;
      out_cell.inv  <= inv_c;
    end
  end

  assign out_valid = v3;

endmodule

// File: design/hpt_div_cell.sv
// One restoring division step for both coordinates.
module hpt_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  hpt_pkg::cell_t in_cell,
  output logic           out_valid,
  input  logic           out_ready,
  output hpt_pkg::cell_t out_cell
);

  logic                   vld;
  logic [hpt_pkg::DW:0]   r2x, r2y, dd;
  logic                   gex, gey;
  hpt_pkg::cell_t         nxt;

  assign in_ready = !vld || out_ready;

  always_comb begin
    dd     = {1'b0, in_cell.d};
    r2x    = {in_cell.rx, 1'b0};
    r2y    = {in_cell.ry, 1'b0};
    gex    = r2x >= dd;
    gey    = r2y >= dd;
    nxt    = in_cell;
    nxt.rx = gex ? hpt_pkg::DW'(r2x - dd) : r2x[hpt_pkg::DW-1:0];
    nxt.ry = gey ? hpt_pkg::DW'(r2y - dd) : r2y[hpt_pkg::DW-1:0];
    nxt.qx = {in_cell.qx[hpt_pkg::QW-2:0], gex};
    nxt.qy = {in_cell.qy[hpt_pkg::QW-2:0], gey};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_cell <= nxt;
    end
  end

  assign out_valid = vld;

endmodule

// File: design/hpt_back.sv
// Rounding, saturation and the output register.
module hpt_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  hpt_pkg::cell_t                in_cell,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [hpt_pkg::OW-1:0] dst_x,
  output logic signed [hpt_pkg::OW-1:0] dst_y,
  output logic                          invalid,
  output logic                          saturated
);

  logic                          vld;
  logic signed [hpt_pkg::OW-1:0] vx, vy;
  logic                          sx, sy;

  // Round half away from zero from the doubled quotient, then clip.
  function automatic logic [hpt_pkg::OW:0] finish(input logic [hpt_pkg::QW-1:0] q,
                                                  input logic neg, input logic ov);
    logic [hpt_pkg::QW:0]   mag;
    logic                   sat;
    logic [hpt_pkg::OW-1:0] val;
    mag = ov ? ((hpt_pkg::QW+1)'(1) << (hpt_pkg::QW-1)) :
               (({1'b0, q} + (hpt_pkg::QW+1)'(1)) >> 1);
    if (!neg) begin
      sat = mag > (hpt_pkg::QW+1)'(524287);
      val = sat ? hpt_pkg::OUT_MAX : mag[hpt_pkg::OW-1:0];
    end else begin
      sat = mag > (hpt_pkg::QW+1)'(524288);
      val = sat ? hpt_pkg::OUT_MIN : hpt_pkg::OW'(-mag[hpt_pkg::OW-1:0]);
    end
    return {sat, val};
  endfunction

  assign in_ready = !vld || out_ready;

  always_comb begin
    {sx, vx} = finish(in_cell.qx, in_cell.negx, in_cell.ovx);
    {sy, vy} = finish(in_cell.qy, in_cell.negy, in_cell.ovy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      dst_x     <= in_cell.inv ? '0 : vx;
      dst_y     <= in_cell.inv ? '0 : vy;
      invalid   <= in_cell.inv;
      saturated <= !in_cell.inv && (sx || sy);
    end
  end

  assign out_valid = vld;

endmodule

// File: design/homography_point_transform.sv
// Homography point transform: maps (src_x, src_y) through a 3x3 projective matrix.
// One point per clock while the output is not stalled. The path holds 26 register
// stages: three front stages (products, sums, magnitude and overflow setup), a row
// of 22 division cells that each settle one bit of the doubled quotient for both
// coordinates, and one rounding/saturation stage that is also the output register.
// Every stage has its own valid bit, so bubbles close up and a new point is taken
// while a finished result waits. Registers are to be written via the cfg channel
// only while the block is idle; the block itself does not enforce this. A write to
// an index above 7 is ignored.
module homography_point_transform (
  input  logic          clk,
  input  logic          rst,
  hpt_point_if.sink     src,
  hpt_result_if.source  dst,
  hpt_cfg_if.sink       cfg
);

  hpt_pkg::coef_t coef [hpt_pkg::NUM_REGS];

  // Handshake and payload taps along the chain: index 0 leaves the front.
  logic           cv  [hpt_pkg::QW+1];
  logic           crdy[hpt_pkg::QW+1];
  hpt_pkg::cell_t cc  [hpt_pkg::QW+1];

  // Configuration registers: always ready, decode the index.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef[hpt_pkg::REG_COEF_XX]  <= hpt_pkg::UNITY;
      coef[hpt_pkg::REG_COEF_XY]  <= '0;
      coef[hpt_pkg::REG_OFFSET_X] <= '0;
      coef[hpt_pkg::REG_COEF_YX]  <= '0;
      coef[hpt_pkg::REG_COEF_YY]  <= hpt_pkg::UNITY;
      coef[hpt_pkg::REG_OFFSET_Y] <= '0;
      coef[hpt_pkg::REG_PERSP_X]  <= '0;
      coef[hpt_pkg::REG_PERSP_Y]  <= '0;
    end else if (cfg.valid && cfg.index < hpt_pkg::IW'(hpt_pkg::NUM_REGS)) begin
      // Drop writes beyond the register list.
      unique case (cfg.index[hpt_pkg::AW-1:0])
        hpt_pkg::REG_COEF_XX:  coef[hpt_pkg::REG_COEF_XX]  <= cfg.data;
        hpt_pkg::REG_COEF_XY:  coef[hpt_pkg::REG_COEF_XY]  <= cfg.data;
        hpt_pkg::REG_OFFSET_X: coef[hpt_pkg::REG_OFFSET_X] <= cfg.data;
        hpt_pkg::REG_COEF_YX:  coef[hpt_pkg::REG_COEF_YX]  <= cfg.data;
        hpt_pkg::REG_COEF_YY:  coef[hpt_pkg::REG_COEF_YY]  <= cfg.data;
        hpt_pkg::REG_OFFSET_Y: coef[hpt_pkg::REG_OFFSET_Y] <= cfg.data;
        hpt_pkg::REG_PERSP_X:  coef[hpt_pkg::REG_PERSP_X]  <= cfg.data;
        hpt_pkg::REG_PERSP_Y:  coef[hpt_pkg::REG_PERSP_Y]  <= cfg.data;
      endcase
    end
  end

  // Form u, v, w and set up the division.
  hpt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (src.valid),
    .in_ready  (src.ready),
    .x         (src.src_x),
    .y         (src.src_y),
    .coef      (coef),
    .out_valid (cv[0]),
    .out_ready (crdy[0]),
    .out_cell  (cc[0])
  );

  // Division row: each cell hands its remainder and quotient to the next.
  for (genvar k = 0; k < hpt_pkg::QW; k++) begin : g_cell
    hpt_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[k]),
      .in_ready  (crdy[k]),
      .in_cell   (cc[k]),
      .out_valid (cv[k+1]),
      .out_ready (crdy[k+1]),
      .out_cell  (cc[k+1])
    );
  end

  // Round, clip and hold the result until taken.
  hpt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cv[hpt_pkg::QW]),
    .in_ready  (crdy[hpt_pkg::QW]),
    .in_cell   (cc[hpt_pkg::QW]),
    .out_valid (dst.valid),
    .out_ready (dst.ready),
    .dst_x     (dst.dst_x),
    .dst_y     (dst.dst_y),
    .invalid   (dst.invalid),
    .saturated (dst.saturated)
  );

endmodule

// File: design/hpt_checker.sv
// Port-level checks of the homography point transform, bound to the top level.
module hpt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [hpt_pkg::OW-1:0] dst_x,
  input logic signed [hpt_pkg::OW-1:0] dst_y,
  input logic                          invalid,
  input logic                          saturated
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(dst_x) && $stable(dst_y))
    else $error("result dropped or changed while stalled");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_inv: assert property (@(posedge clk) disable iff (rst)
    out_valid && invalid |-> dst_x == '0 && dst_y == '0 && !saturated)
    else $error("invalid point carries nonzero fields");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      dst_x == hpt_pkg::OUT_MAX || dst_x == hpt_pkg::OUT_MIN ||
      dst_y == hpt_pkg::OUT_MAX || dst_y == hpt_pkg::OUT_MIN)
    else $error("saturated flag without a clipped coordinate");

endmodule

bind homography_point_transform hpt_checker u_hpt_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (dst.valid),
  .out_ready (dst.ready),
  .dst_x     (dst.dst_x),
  .dst_y     (dst.dst_y),
  .invalid   (dst.invalid),
  .saturated (dst.saturated)
);
